FILE: rtl/dcd_pkg.sv
package dcd_pkg;

  // Default storage sizes
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int MARKER_DEPTH_DEF  = 64;

  // Field widths
  localparam int POS_W     = 24;
  localparam int PID_W     = 8;
  localparam int TOTAL_W   = 7;
  localparam int RAD_W     = 49;
  localparam int HITS_W    = 5;
  localparam int OFFS_W    = 12;

  // Distance arithmetic: magnitude, square, sum of two squares
  localparam int MAG_W     = 25;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RAD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_RADIUS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_HITS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_OFFSET    = 2'd3;

  // Register reset values
  localparam logic [RAD_W-1:0]  CONFIRM_RADIUS_RST = 49'd16384;
  localparam logic [RAD_W-1:0]  EXCL_RADIUS_RST    = 49'd262144;
  localparam logic [HITS_W-1:0] CONFIRM_HITS_RST   = 5'd3;
  localparam logic [OFFS_W-1:0] TEXT_OFFSET_RST    = 12'd77;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIST,
    ST_DECIDE,
    ST_MARK,
    ST_STORE,
    ST_DONE
  } dcd_state_t;

endpackage

FILE: rtl/dcd_if.sv
// Detection input channel
interface dcd_in_if;
  import dcd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [PID_W-1:0]        person_id;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output person_id, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input person_id, output ready);
endinterface

// Result channel
interface dcd_out_if;
  import dcd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    new_marker;
  logic                    table_full;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic signed [POS_W-1:0] out_z;
  logic [PID_W-1:0]        out_person;
  logic [TOTAL_W-1:0]      marker_total;

  modport source (output valid, output new_marker, output table_full, output out_x,
                  output out_y, output out_z, output out_person, output marker_total,
                  input ready);
  modport sink   (input valid, input new_marker, input table_full, input out_x,
                  input out_y, input out_z, input out_person, input marker_total,
                  output ready);
endinterface

FILE: rtl/detection_confirm_and_dedup.sv
// Channel   Direction  Payload
// in_ch     sink       pos_x, pos_y, pos_z, person_id
// out_ch    source     new_marker, table_full, out_x, out_y, out_z, out_person,
//                      marker_total
// cfg_*     write      cfg_index selects register, cfg_data carries the value
//
// One point at a time. The history memory is read one entry per cycle through a
// distance pipeline of read register, magnitudes, squares and sums; a confirmed
// point then scans the marker table the same way.
// Synchronous active-low reset empties history and marker table; no clearing pass.
// A finished result waits in the output register while the next point is taken.
module detection_confirm_and_dedup #(
  parameter int HISTORY_DEPTH = dcd_pkg::HISTORY_DEPTH_DEF,
  parameter int MARKER_DEPTH  = dcd_pkg::MARKER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dcd_in_if.sink                          in_ch,
  dcd_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [dcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dcd_pkg::*;

  localparam int HA_W = $clog2(HISTORY_DEPTH);
  localparam int HC_W = $clog2(HISTORY_DEPTH + 1);
  localparam int HS_W = HC_W + 1;
  localparam int MA_W = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
  localparam int MC_W = $clog2(MARKER_DEPTH + 1);
  localparam int XY_W = 2 * POS_W;

  localparam logic [HS_W-1:0] H_DEPTH_S = HS_W'(HISTORY_DEPTH);
  localparam logic [HC_W-1:0] H_DEPTH_C = HC_W'(HISTORY_DEPTH);
  localparam logic [HC_W-1:0] H_LAST_C  = HC_W'(HISTORY_DEPTH - 1);
  localparam logic [HA_W-1:0] H_LAST_A  = HA_W'(HISTORY_DEPTH - 1);
  localparam logic [MC_W-1:0] M_DEPTH_C = MC_W'(MARKER_DEPTH);

  // Configuration registers
  logic [RAD_W-1:0]  confirm_radius_r;
  logic [RAD_W-1:0]  excl_radius_r;
  logic [HITS_W-1:0] confirm_hits_r;
  logic [OFFS_W-1:0] text_offset_r;

  // Sequencer
  dcd_state_t state_r, state_nxt;

  // Current point
  logic [POS_W-1:0] px_r, py_r, pz_r;
  logic [PID_W-1:0] pid_r;

  // History ring and marker table bookkeeping
  logic [HA_W-1:0] hhead_r;
  logic [HC_W-1:0] hcnt_r;
  logic [MC_W-1:0] mcnt_r;
  logic [HC_W-1:0] hidx_r;
  logic [MC_W-1:0] midx_r;
  logic [HC_W-1:0] hits_r;
  logic            excl_r;
  logic            newm_r;
  logic            full_r;

  // Memories and their read registers
  logic [XY_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [XY_W-1:0] mark_mem [MARKER_DEPTH];
  logic [XY_W-1:0] hist_rd_r;
  logic [XY_W-1:0] mark_rd_r;

  // Distance pipeline
  logic             rd_vld_r, mag_vld_r, sq_vld_r;
  logic [MAG_W-1:0] magx_r, magy_r, mago_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r, sqo_r;

  // Output register
  logic               ovld_r;
  logic               onew_r, ofull_r;
  logic [POS_W-1:0]   ox_r, oy_r, oz_r;
  logic [PID_W-1:0]   opid_r;
  logic [TOTAL_W-1:0] otot_r;

  // Control decodes
  logic in_xfer, hist_issue, mark_issue, scan_busy, accepted, out_load;
  logic hist_we, mark_we;

  // History read address: head plus scan index, wrapped
  logic [HS_W-1:0] hsum;
  logic [HA_W-1:0] haddr;
  always_comb begin
    hsum  = HS_W'(hhead_r) + HS_W'(hidx_r);
    if (hsum >= H_DEPTH_S) begin
      hsum = hsum - H_DEPTH_S;
    end
    haddr = hsum[HA_W-1:0];
  end

  // History write slot after dropping the oldest entry when full
  logic            hfull;
  logic [HA_W-1:0] head_adj;
  logic [HC_W-1:0] cnt_adj;
  logic [HS_W-1:0] wsum;
  logic [HA_W-1:0] hwaddr;
  always_comb begin
    hfull    = (hcnt_r == H_DEPTH_C);
    head_adj = hhead_r;
    cnt_adj  = hcnt_r;
    if (hfull) begin
      head_adj = (hhead_r == H_LAST_A) ? '0 : hhead_r + 1'b1;
      cnt_adj  = H_LAST_C;
    end
    wsum = HS_W'(head_adj) + HS_W'(cnt_adj);
    if (wsum >= H_DEPTH_S) begin
      wsum = wsum - H_DEPTH_S;
    end
    hwaddr = wsum[HA_W-1:0];
  end

  // Hits against the threshold, both zero-extended
  assign accepted = ({{HITS_W{1'b0}}, hits_r} >= {{HC_W{1'b0}}, confirm_hits_r});

  // Control outputs
  always_comb begin
    in_xfer    = in_ch.valid && (state_r == ST_IDLE);
    hist_issue = (state_r == ST_HIST) && (hidx_r < hcnt_r);
    mark_issue = (state_r == ST_MARK) && (midx_r < mcnt_r);
    scan_busy  = rd_vld_r || mag_vld_r || sq_vld_r;
    hist_we    = (state_r == ST_DECIDE) && !accepted;
    mark_we    = (state_r == ST_STORE) && !excl_r && (mcnt_r < M_DEPTH_C);
    out_load   = (state_r == ST_DONE) && (!ovld_r || out_ch.ready);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_HIST;
      end
      ST_HIST: begin
        if (!hist_issue && !scan_busy) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = accepted ? ST_MARK : ST_DONE;
      end
      ST_MARK: begin
        if (!mark_issue && !scan_busy) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirm_radius_r <= CONFIRM_RADIUS_RST;
      excl_radius_r    <= EXCL_RADIUS_RST;
      confirm_hits_r   <= CONFIRM_HITS_RST;
      text_offset_r    <= TEXT_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONFIRM_RADIUS: confirm_radius_r <= cfg_data;
        CFG_EXCL_RADIUS:    excl_radius_r    <= cfg_data;
        CFG_CONFIRM_HITS:   confirm_hits_r   <= cfg_data[HITS_W-1:0];
        CFG_TEXT_OFFSET:    text_offset_r    <= cfg_data[OFFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hwaddr] <= {px_r, py_r};
    end
    if (hist_issue) begin
      hist_rd_r <= hist_mem[haddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mcnt_r[MA_W-1:0]] <= {px_r, py_r};
    end
    if (mark_issue) begin
      mark_rd_r <= mark_mem[midx_r[MA_W-1:0]];
    end
  end

  // Pipeline stage 1: coordinate differences to magnitudes
  logic [XY_W-1:0]  ent;
  logic [MAG_W-1:0] dx, dy, negx, negy;
  logic [MAG_W:0]   dyo, nego;
  always_comb begin
    ent  = (state_r == ST_HIST) ? hist_rd_r : mark_rd_r;
    dx   = {px_r[POS_W-1], px_r} - {ent[XY_W-1], ent[XY_W-1:POS_W]};
    dy   = {py_r[POS_W-1], py_r} - {ent[POS_W-1], ent[POS_W-1:0]};
    dyo  = {{2{py_r[POS_W-1]}}, py_r} - {{2{ent[POS_W-1]}}, ent[POS_W-1:0]}
           + {{(MAG_W+1-OFFS_W){1'b0}}, text_offset_r};
    negx = ~dx + 1'b1;
    negy = ~dy + 1'b1;
    nego = ~dyo + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      magx_r <= dx[MAG_W-1] ? negx : dx;
      magy_r <= dy[MAG_W-1] ? negy : dy;
      mago_r <= dyo[MAG_W] ? nego[MAG_W-1:0] : dyo[MAG_W-1:0];
    end
  end

  // Pipeline stage 2: squares
  always_ff @(posedge clk) begin
    if (mag_vld_r) begin
      sqx_r <= magx_r * magx_r;
      sqy_r <= magy_r * magy_r;
      sqo_r <= mago_r * mago_r;
    end
  end

  // Pipeline stage 3: sums against the active limit
  logic [SUM_W-1:0] sum_a, sum_b, lim;
  logic             near_a, near_b;
  always_comb begin
    sum_a  = {1'b0, sqx_r} + {1'b0, sqy_r};
    sum_b  = {1'b0, sqx_r} + {1'b0, sqo_r};
    lim    = (state_r == ST_HIST) ? {2'b00, confirm_radius_r} : {2'b00, excl_radius_r};
    near_a = (sum_a < lim);
    near_b = (sum_b < lim);
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mag_vld_r <= 1'b0;
      sq_vld_r  <= 1'b0;
    end else begin
      rd_vld_r  <= hist_issue || mark_issue;
      mag_vld_r <= rd_vld_r;
      sq_vld_r  <= mag_vld_r;
    end
  end

  // Item bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hhead_r <= '0;
      hcnt_r  <= '0;
      mcnt_r  <= '0;
    end else begin
      if (hist_we) begin
        hhead_r <= head_adj;
        hcnt_r  <= cnt_adj + 1'b1;
      end else if ((state_r == ST_DECIDE) && accepted) begin
        hhead_r <= '0;
        hcnt_r  <= '0;
      end
      if (mark_we) begin
        mcnt_r <= mcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px_r   <= in_ch.pos_x;
      py_r   <= in_ch.pos_y;
      pz_r   <= in_ch.pos_z;
      pid_r  <= in_ch.person_id;
      hidx_r <= '0;
      midx_r <= '0;
      hits_r <= '0;
      excl_r <= 1'b0;
      newm_r <= 1'b0;
      full_r <= 1'b0;
    end else begin
      if (hist_issue) hidx_r <= hidx_r + 1'b1;
      if (mark_issue) midx_r <= midx_r + 1'b1;
      if (sq_vld_r && (state_r == ST_HIST) && near_a) begin
        hits_r <= hits_r + 1'b1;
      end
      if (sq_vld_r && (state_r == ST_MARK) && (near_a || near_b)) begin
        excl_r <= 1'b1;
      end
      if ((state_r == ST_STORE) && !excl_r) begin
        newm_r <= mark_we;
        full_r <= !mark_we;
      end
    end
  end

  // Output register
  logic [MC_W+TOTAL_W-1:0] mtot_ext;
  assign mtot_ext = {{TOTAL_W{1'b0}}, mcnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= out_load || (ovld_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      onew_r  <= newm_r;
      ofull_r <= full_r;
      ox_r    <= px_r;
      oy_r    <= py_r;
      oz_r    <= pz_r;
      opid_r  <= pid_r;
      otot_r  <= mtot_ext[TOTAL_W-1:0];
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = ovld_r;
  assign out_ch.new_marker   = onew_r;
  assign out_ch.table_full   = ofull_r;
  assign out_ch.out_x        = ox_r;
  assign out_ch.out_y        = oy_r;
  assign out_ch.out_z        = oz_r;
  assign out_ch.out_person   = opid_r;
  assign out_ch.marker_total = otot_r;

endmodule

FILE: bench/dcd_verdict_check.sv
// Watches both channels and the register port, keeps its own copy of the
// detection history and marker table, and checks every result transfer.
module dcd_verdict_check (
  input  logic                           clk,
  input  logic                           rst_n,
  dcd_in_if                              in_ch,
  dcd_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [dcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import dcd_pkg::*;

  typedef struct packed {
    logic               new_marker;
    logic               table_full;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
    logic [PID_W-1:0]   person;
    logic [TOTAL_W-1:0] total;
  } verdict_t;

  // Register copies
  logic [RAD_W-1:0]  confirm_rsq = CONFIRM_RADIUS_RST;
  logic [RAD_W-1:0]  excl_rsq    = EXCL_RADIUS_RST;
  logic [HITS_W-1:0] hits_need   = CONFIRM_HITS_RST;
  logic [OFFS_W-1:0] text_offs   = TEXT_OFFSET_RST;

  // Unconfirmed detections (ring) and stored markers
  longint hist_x [HISTORY_DEPTH_DEF];
  longint hist_y [HISTORY_DEPTH_DEF];
  int     hist_count = 0;
  int     hist_head  = 0;
  longint mark_x [MARKER_DEPTH_DEF];
  longint mark_y [MARKER_DEPTH_DEF];
  int     mark_count = 0;

  verdict_t verdicts [$];
  int       mismatch_count = 0;

  assign fail_count = mismatch_count + pending;

  function automatic longint plane_dist_sq(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy;
  endfunction

  // Confirms the point against history, then deduplicates against markers
  function automatic verdict_t judge_detection(input logic signed [POS_W-1:0] px_in,
                                               input logic signed [POS_W-1:0] py_in,
                                               input logic [POS_W-1:0] pz,
                                               input logic [PID_W-1:0] pid);
    longint   px, py;
    int       hits, slot, i;
    logic     excluded;
    verdict_t v;
    px = px_in;
    py = py_in;
    v = '0;
    v.x = px_in;
    v.y = py_in;
    v.z = pz;
    v.person = pid;
    hits = 0;
    for (i = 0; i < hist_count; i++) begin
      slot = (hist_head + i) % HISTORY_DEPTH_DEF;
      if (plane_dist_sq(px, py, hist_x[slot], hist_y[slot]) < longint'(confirm_rsq))
        hits++;
    end
    if (hits < int'(hits_need)) begin
      // not confirmed: append to the ring, dropping the oldest when full
      if (hist_count >= HISTORY_DEPTH_DEF) begin
        hist_head  = (hist_head + 1) % HISTORY_DEPTH_DEF;
        hist_count = HISTORY_DEPTH_DEF - 1;
      end
      slot = (hist_head + hist_count) % HISTORY_DEPTH_DEF;
      hist_x[slot] = px;
      hist_y[slot] = py;
      hist_count++;
    end else begin
      hist_count = 0;
      hist_head  = 0;
      excluded   = 1'b0;
      for (i = 0; i < mark_count; i++) begin
        if (plane_dist_sq(px, py, mark_x[i], mark_y[i]) < longint'(excl_rsq) ||
            plane_dist_sq(px, py, mark_x[i], mark_y[i] - longint'(text_offs))
              < longint'(excl_rsq))
          excluded = 1'b1;
      end
      if (!excluded) begin
        if (mark_count < MARKER_DEPTH_DEF) begin
          mark_x[mark_count] = px;
          mark_y[mark_count] = py;
          mark_count++;
          v.new_marker = 1'b1;
        end else begin
          v.table_full = 1'b1;
        end
      end
    end
    v.total = TOTAL_W'(mark_count);
    return v;
  endfunction

  task automatic compare_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    verdict_t fresh;
    if (!rst_n) begin
      confirm_rsq = CONFIRM_RADIUS_RST;
      excl_rsq    = EXCL_RADIUS_RST;
      hits_need   = CONFIRM_HITS_RST;
      text_offs   = TEXT_OFFSET_RST;
      hist_count  = 0;
      hist_head   = 0;
      mark_count  = 0;
      verdicts.delete();
    end else begin
      // result transfer first, so a stray result never meets this edge's input
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts.size() == 0) begin
          $display("%0t: result with nothing expected, got nm %0d tf %0d x %0h y %0h total %0d",
                   $time, out_ch.new_marker, out_ch.table_full, out_ch.out_x,
                   out_ch.out_y, out_ch.marker_total);
          mismatch_count++;
        end else begin
          want = verdicts.pop_front();
          compare_field("new_marker", POS_W'(want.new_marker), POS_W'(out_ch.new_marker));
          compare_field("table_full", POS_W'(want.table_full), POS_W'(out_ch.table_full));
          compare_field("out_x", want.x, out_ch.out_x);
          compare_field("out_y", want.y, out_ch.out_y);
          compare_field("out_z", want.z, out_ch.out_z);
          compare_field("out_person", POS_W'(want.person), POS_W'(out_ch.out_person));
          compare_field("marker_total", POS_W'(want.total), POS_W'(out_ch.marker_total));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        fresh = judge_detection(in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.person_id);
        verdicts.insert(verdicts.size(), fresh);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CONFIRM_RADIUS: confirm_rsq = cfg_data;
          CFG_EXCL_RADIUS:    excl_rsq    = cfg_data;
          CFG_CONFIRM_HITS:   hits_need   = cfg_data[HITS_W-1:0];
          CFG_TEXT_OFFSET:    text_offs   = cfg_data[OFFS_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= verdicts.size();
  end

endmodule

FILE: bench/detection_confirm_and_dedup_test.sv
// Drives detections and register settings into the block; checking is done
// by the checker instance beside it.
module detection_confirm_and_dedup_test;
  import dcd_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SITE_COUNT  = 24;
  localparam int SITE_SPAN   = 8383608;  // keeps offset probes and jitter in range
  localparam int BUSY_ITEMS  = 240;
  localparam int DULL_ITEMS  = 120;

  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    idle_cycles = 0;
  bit                    quiet = 1'b0;

  // settings in force, used to shape the stimulus
  logic [RAD_W-1:0]  cur_confirm = CONFIRM_RADIUS_RST;
  logic [HITS_W-1:0] cur_hits    = CONFIRM_HITS_RST;
  logic [OFFS_W-1:0] cur_offs    = TEXT_OFFSET_RST;

  longint site_x [SITE_COUNT];
  longint site_y [SITE_COUNT];

  dcd_in_if  in_ch ();
  dcd_out_if out_ch ();

  detection_confirm_and_dedup uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dcd_verdict_check check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: cycles with no transfer and no register write
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random stall bursts unless quiet
  initial begin : result_drain
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && !quiet && $urandom_range(0, 5) == 0)
        stall = $urandom_range(1, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One detection transfer, with an optional gap before it
  task automatic send_detection(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                input logic [POS_W-1:0] z, input logic [PID_W-1:0] pid);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 7)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pos_x     <= x;
    in_ch.pos_y     <= y;
    in_ch.pos_z     <= z;
    in_ch.person_id <= pid;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Wait until every result has come back
  task automatic settle;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Narrow registers get random upper bits, which the block must drop
  task automatic set_phase(input logic [RAD_W-1:0] confirm, input logic [RAD_W-1:0] excl,
                           input logic [HITS_W-1:0] hits, input logic [OFFS_W-1:0] offs);
    logic [CFG_DATA_W-1:0] junk;
    settle();
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(CFG_CONFIRM_RADIUS, confirm);
    write_reg(CFG_EXCL_RADIUS, excl);
    write_reg(CFG_CONFIRM_HITS, {junk[CFG_DATA_W-1:HITS_W], hits});
    write_reg(CFG_TEXT_OFFSET, {junk[CFG_DATA_W-1:OFFS_W], offs});
    cur_confirm = confirm;
    cur_hits    = hits;
    cur_offs    = offs;
  endtask

  // Mostly confirmation runs around known sites, the rest scattered noise
  task automatic run_phase(input int quota);
    int     sent, kind, len, jit, dx, dy, s, i;
    longint tx, ty;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) < 7) begin
        kind = $urandom_range(0, 9);
        s    = $urandom_range(0, SITE_COUNT - 1);
        tx   = site_x[s];
        ty   = site_y[s];
        if (kind < 2) begin
          ty = ty - longint'(cur_offs);  // lands on a marker's text point
        end else if (kind == 2) begin
          tx = longint'($urandom_range(0, 2 * SITE_SPAN)) - SITE_SPAN;
          ty = longint'($urandom_range(0, 2 * SITE_SPAN)) - SITE_SPAN;
        end
        jit = (cur_confirm >= 16384) ? 40 : 0;
        len = (cur_hits > 16) ? int'($urandom_range(2, 6))
                              : int'(cur_hits) + int'($urandom_range(0, 2));
        if (len == 0) len = 1;
        for (i = 0; i < len; i++) begin
          dx = int'($urandom_range(0, 2 * jit)) - jit;
          dy = int'($urandom_range(0, 2 * jit)) - jit;
          send_detection(POS_W'(tx + dx), POS_W'(ty + dy), POS_W'($urandom),
                         PID_W'($urandom));
        end
        sent += len;
      end else begin
        len = $urandom_range(1, 3);
        for (i = 0; i < len; i++)
          send_detection(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                         PID_W'($urandom));
        sent += len;
      end
    end
  endtask

  initial begin : stimulus
    int i;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.pos_x     = '0;
    in_ch.pos_y     = '0;
    in_ch.pos_z     = '0;
    in_ch.person_id = '0;
    for (i = 0; i < SITE_COUNT; i++) begin
      site_x[i] = longint'($urandom_range(0, 2 * SITE_SPAN)) - SITE_SPAN;
      site_y[i] = longint'($urandom_range(0, 2 * SITE_SPAN)) - SITE_SPAN;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: confirm at a corner, repeat it (excluded), then the far corner
    repeat (4) send_detection(POS_MIN, POS_MAX, POS_MIN, 8'h00);
    repeat (4) send_detection(POS_MIN, POS_MAX, '0, 8'h5A);
    repeat (4) send_detection(POS_MAX, POS_MIN, POS_MAX, 8'hFF);

    // Every point accepted, exact exclusion only, text point far below the marker
    set_phase(CONFIRM_RADIUS_RST, RAD_W'(1), '0, OFFS_W'(2560));
    send_detection(POS_W'(1000), POS_W'(5000), POS_W'(7), 8'h01);
    send_detection(POS_W'(1000), POS_W'(5000 - 2560), POS_W'(7), 8'h02);
    send_detection(POS_W'(1000), POS_W'(5000 - 1280), POS_W'(7), 8'h03);
    send_detection(POS_W'(1000), POS_W'(5000), POS_W'(7), 8'h04);

    // More hits needed than the ring can hold: nothing is ever accepted
    set_phase(RAD_MAX, EXCL_RADIUS_RST, HITS_W'(17), TEXT_OFFSET_RST);
    repeat (3) send_detection(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                              PID_W'($urandom));

    set_phase(CONFIRM_RADIUS_RST, EXCL_RADIUS_RST, CONFIRM_HITS_RST, TEXT_OFFSET_RST);
    run_phase(BUSY_ITEMS);
    set_phase(RAD_W'(1 << 20), EXCL_RADIUS_RST, HITS_W'(1), OFFS_W'(2560));
    run_phase(BUSY_ITEMS);
    quiet = 1'b1;
    set_phase(RAD_MAX, RAD_W'(1), HITS_W'(16), '0);
    run_phase(BUSY_ITEMS);
    quiet = 1'b0;
    set_phase(RAD_W'(1), RAD_MAX, HITS_W'(5), OFFS_W'(1234));
    run_phase(BUSY_ITEMS);
    set_phase(CONFIRM_RADIUS_RST, '0, {HITS_W{1'b1}}, {OFFS_W{1'b1}});
    run_phase(DULL_ITEMS);
    quiet = 1'b1;
    set_phase('0, EXCL_RADIUS_RST, HITS_W'(2), OFFS_W'(640));
    run_phase(DULL_ITEMS);
    quiet = 1'b0;
    // everything accepted and nothing excluded: the marker table fills up
    set_phase(CONFIRM_RADIUS_RST, '0, '0, TEXT_OFFSET_RST);
    run_phase(BUSY_ITEMS);
    set_phase(RAD_W'(65536), EXCL_RADIUS_RST, HITS_W'(4), OFFS_W'(300));
    quiet = 1'b1;
    run_phase(BUSY_ITEMS);

    settle();
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dcd_pkg.sv
rtl/dcd_if.sv
rtl/detection_confirm_and_dedup.sv
bench/dcd_verdict_check.sv
bench/detection_confirm_and_dedup_test.sv
